@@ design/itp_pkg.sv @@
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, constants and helpers for the infix to postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TERM  = 8'h00;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_OPER
  } kind_e;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } stack_cmd_t;

  typedef struct packed {
    logic [7:0] top;
    logic       empty;
    logic       full;
  } stack_sts_t;

  typedef struct packed {
    kind_e kind;
    logic  pop_emit;
    logic  pop_drop;
  } step_dec_t;

  function automatic logic is_high_prec(input logic [7:0] c);
    return (c == CH_MUL) || (c == CH_DIV);
  endfunction

endpackage

`default_nettype wire

@@ design/itp_stack.sv @@
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack: register file with a fill count, one push or pop a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_stack
  import itp_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  stack_cmd_t cmd_i,
  output stack_sts_t sts_o
);

  logic [7:0]       mem_q [STACK_DEPTH];
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  logic [CNT_W-1:0] cnt_m1;
  logic             full;
  logic             empty;

  assign full   = (cnt_q == CNT_W'(STACK_DEPTH));
  assign empty  = (cnt_q == '0);
  assign cnt_m1 = cnt_q - CNT_W'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.push && !full) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.pop && !empty) begin
      cnt_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) begin
      mem_q[cnt_q[PTR_W-1:0]] <= cmd_i.wdata;
    end
  end

  assign sts_o.top   = mem_q[cnt_m1[PTR_W-1:0]];
  assign sts_o.empty = empty;
  assign sts_o.full  = full;

endmodule

`default_nettype wire

@@ design/itp_cmp.sv @@
// ----------------------------------------------------------------------------
// itp_cmp
// Character classifier and precedence compare against the stack top.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_cmp
  import itp_pkg::*;
(
  input  wire  [7:0] char_i,
  input  wire  [7:0] top_i,
  input  wire        empty_i,
  output step_dec_t  dec_o
);

  logic top_open;
  logic prec_ok;

  assign top_open = (top_i == CH_OPEN);
  assign prec_ok  = !(is_high_prec(char_i) && !is_high_prec(top_i));

  always_comb begin
    dec_o.pop_emit = 1'b0;
    dec_o.pop_drop = 1'b0;
    if (char_i inside {[CH_ZERO:CH_NINE]}) begin
      dec_o.kind = KIND_DIGIT;
    end else if (char_i == CH_OPEN) begin
      dec_o.kind = KIND_OPEN;
    end else if (char_i == CH_CLOSE) begin
      dec_o.kind     = KIND_CLOSE;
      dec_o.pop_emit = !empty_i && !top_open;
      dec_o.pop_drop = !empty_i && top_open;
    end else begin
      dec_o.kind     = KIND_OPER;
      dec_o.pop_emit = !empty_i && !top_open && prec_ok;
    end
  end

endmodule

`default_nettype wire

@@ design/infix_to_postfix_converter_core.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter: one character item in, postfix character items out.
// Each character runs in S_PROC; results pass the pending, then output register.
// The last item also flushes the stack and emits the terminator. Input is taken
// only in S_IDLE; single compare step, one push or pop per cycle if output free.
// Reset: stack empty, overflow flag clear, no result pending, input ready.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_core
  import itp_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,  // [7:0] in_char
  input  wire        s_axis_tlast,  // end_of_expr
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_char
  output logic       m_axis_tlast,  // run_last
  output logic [1:0] m_axis_tuser   // [0] expr_done, [1] overflow_seen
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROC  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       ovf_q, ovf_d;

  logic       pend_vld_q, pend_vld_d;
  logic [7:0] pend_char_q, pend_char_d;
  logic       pend_done_q, pend_done_d;
  logic       pend_ovf_q, pend_ovf_d;

  logic       out_vld_q, out_vld_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;
  logic [1:0] out_user_q, out_user_d;

  stack_cmd_t stk_cmd;
  stack_sts_t stk_sts;
  step_dec_t  dec;

  logic       out_free;
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_done;
  logic       item_end;

  itp_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stk_cmd),
    .sts_o  (stk_sts)
  );

  itp_cmp u_cmp (
    .char_i  (char_q),
    .top_i   (stk_sts.top),
    .empty_i (stk_sts.empty),
    .dec_o   (dec)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    char_d      = char_q;
    last_d      = last_q;
    ovf_d       = ovf_q;
    stk_cmd     = '{push: 1'b0, pop: 1'b0, wdata: char_q};
    emit        = 1'b0;
    emit_char   = stk_sts.top;
    emit_done   = 1'b0;
    item_end    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          char_d  = s_axis_tdata;
          last_d  = s_axis_tlast;
          state_d = S_PROC;
        end
      end
      S_PROC: begin
        if (out_free) begin
          case (dec.kind)
            KIND_DIGIT: begin
              emit      = 1'b1;
              emit_char = char_q;
              item_end  = 1'b1;
            end
            KIND_OPEN: begin
              stk_cmd.push = 1'b1;
              item_end     = 1'b1;
            end
            KIND_CLOSE: begin
              if (dec.pop_emit) begin
                emit        = 1'b1;
                stk_cmd.pop = 1'b1;
              end else begin
                stk_cmd.pop = dec.pop_drop;
                item_end    = 1'b1;
              end
            end
            KIND_OPER: begin
              if (dec.pop_emit) begin
                emit        = 1'b1;
                stk_cmd.pop = 1'b1;
              end else begin
                stk_cmd.push = 1'b1;
                item_end     = 1'b1;
              end
            end
            default: item_end = 1'b1;
          endcase
          if (stk_cmd.push && stk_sts.full) begin
            ovf_d = 1'b1;
          end
          if (item_end) begin
            state_d = last_q ? S_FLUSH : S_FIN;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (!stk_sts.empty) begin
            stk_cmd.pop = 1'b1;
          end else begin
            emit_char = CH_TERM;
            emit_done = 1'b1;
            ovf_d     = 1'b0;
            state_d   = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free || !pend_vld_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pend_vld_d  = pend_vld_q;
    pend_char_d = pend_char_q;
    pend_done_d = pend_done_q;
    pend_ovf_d  = pend_ovf_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_user_d  = out_user_q;

    if (emit) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_char_d = pend_char_q;
        out_last_d = 1'b0;
        out_user_d = {pend_ovf_q, pend_done_q};
      end
      pend_vld_d  = 1'b1;
      pend_char_d = emit_char;
      pend_done_d = emit_done;
      pend_ovf_d  = ovf_q;
    end else if (state_q == S_FIN && out_free && pend_vld_q) begin
      out_vld_d  = 1'b1;
      out_char_d = pend_char_q;
      out_last_d = 1'b1;
      out_user_d = {pend_ovf_q, pend_done_q};
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ovf_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ovf_q      <= ovf_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q      <= char_d;
    last_q      <= last_d;
    pend_char_q <= pend_char_d;
    pend_done_q <= pend_done_d;
    pend_ovf_q  <= pend_ovf_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_user_q  <= out_user_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

@@ tb/infix_to_postfix_converter_core_tb.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core_tb
// Streams infix characters into the converter and checks every postfix item
// against an in-bench shunting-yard predictor: directed precedence, paren,
// stray-paren and stack-overflow cases, then random well-formed, broken and
// noise expressions with random idle bursts on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_core_tb;
  import itp_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       done;
    logic       ovf;
  } postfix_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_char
  logic       s_axis_tlast;   // end_of_expr
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_char
  logic       m_axis_tlast;   // run_last
  logic [1:0] m_axis_tuser;   // [0] expr_done, [1] overflow_seen

  postfix_item_t postfix_q[$];
  logic [7:0]    expr_chars[$];
  logic [7:0]    op_stack[STACK_DEPTH];
  int            op_depth;
  logic          ovf_flag;
  int            error_count;
  int            items_sent;
  logic          idle_enable;
  int            stall_left;

  infix_to_postfix_converter_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int rank_of(input logic [7:0] c);
    return (c == CH_MUL || c == CH_DIV) ? 2 : 1;
  endfunction

  task automatic convert_char(input logic [7:0] c, input logic last);
    postfix_item_t produced[$];
    logic [7:0]    top;
    int            pc;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      produced.push_back('{c, 1'b0, 1'b0, ovf_flag});
    end else if (c == CH_OPEN) begin
      if (op_depth < STACK_DEPTH) begin
        op_stack[op_depth] = c;
        op_depth++;
      end else begin
        ovf_flag = 1'b1;
      end
    end else if (c == CH_CLOSE) begin
      while (op_depth > 0 && op_stack[op_depth-1] != CH_OPEN) begin
        op_depth--;
        produced.push_back('{op_stack[op_depth], 1'b0, 1'b0, ovf_flag});
      end
      if (op_depth > 0) op_depth--;
    end else begin
      pc = rank_of(c);
      while (op_depth > 0) begin
        top = op_stack[op_depth-1];
        if (top == CH_OPEN || rank_of(top) < pc) break;
        op_depth--;
        produced.push_back('{top, 1'b0, 1'b0, ovf_flag});
      end
      if (op_depth < STACK_DEPTH) begin
        op_stack[op_depth] = c;
        op_depth++;
      end else begin
        ovf_flag = 1'b1;
      end
    end
    if (last) begin
      while (op_depth > 0) begin
        op_depth--;
        produced.push_back('{op_stack[op_depth], 1'b0, 1'b0, ovf_flag});
      end
      produced.push_back('{CH_TERM, 1'b0, 1'b1, ovf_flag});
      ovf_flag = 1'b0;
    end
    if (produced.size() > 0) produced[produced.size()-1].run_last = 1'b1;
    foreach (produced[i]) postfix_q.push_back(produced[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch on %s: got %02h, expected %02h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    postfix_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (postfix_q.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata, 8'h00);
      end else begin
        want = postfix_q.pop_front();
        if (m_axis_tdata !== want.ch) report_mismatch("out_char", m_axis_tdata, want.ch);
        if (m_axis_tlast !== want.run_last)
          report_mismatch("run_last", 8'(m_axis_tlast), 8'(want.run_last));
        if (m_axis_tuser[0] !== want.done)
          report_mismatch("expr_done", 8'(m_axis_tuser[0]), 8'(want.done));
        if (m_axis_tuser[1] !== want.ovf)
          report_mismatch("overflow_seen", 8'(m_axis_tuser[1]), 8'(want.ovf));
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 99) < 15) begin
      stall_left    <= $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    @(negedge clk_i);
    if (idle_enable && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    convert_char(c, last);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_expr();
    foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h2B;
      2, 3:    return 8'h2D;
      4, 5:    return CH_MUL;
      6, 7:    return CH_DIV;
      default: return 8'h5E;
    endcase
  endfunction

  task automatic build_expr(input int open_pct, input int max_terms);
    int depth;
    int terms;
    expr_chars.delete();
    depth = 0;
    terms = 0;
    forever begin
      while (depth < 20 && $urandom_range(0, 99) < open_pct) begin
        expr_chars.push_back(CH_OPEN);
        depth++;
      end
      expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      terms++;
      while (depth > 0 && $urandom_range(0, 99) < 40) begin
        expr_chars.push_back(CH_CLOSE);
        depth--;
      end
      if (terms >= max_terms) break;
      expr_chars.push_back(pick_operator());
    end
    while (depth > 0) begin
      expr_chars.push_back(CH_CLOSE);
      depth--;
    end
  endtask

  task automatic test_precedence_and_parens();
    string text;
    text = "9/(0-1)*2";
    for (int i = 0; i < text.len(); i++) send_char(text[i], i == text.len() - 1);
  endtask

  task automatic test_close_on_empty();
    send_char(CH_CLOSE, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_stray_open();
    send_char(CH_OPEN, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_stack_overflow();
    for (int i = 0; i <= STACK_DEPTH; i++) send_char(CH_OPEN, i == STACK_DEPTH);
    drain_results();
  endtask

  task automatic test_random_expressions();
    int pick;
    int pos;
    while (items_sent < 480) begin
      if (items_sent >= 410) idle_enable = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        build_expr($urandom_range(0, 7) * 10, $urandom_range(1, 8));
        if (pick >= 65) begin
          pos = $urandom_range(0, expr_chars.size() - 1);
          if ($urandom_range(0, 1) && expr_chars.size() > 1) expr_chars.delete(pos);
          else expr_chars[pos] = 8'($urandom_range(0, 255));
        end
        send_expr();
      end else begin
        repeat ($urandom_range(1, 6))
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
      if ($urandom_range(0, 99) < 5) drain_results();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    idle_enable   = 1'b1;
    op_depth      = 0;
    ovf_flag      = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_precedence_and_parens();
    test_close_on_empty();
    test_stray_open();
    test_stack_overflow();
    test_random_expressions();

    drain_results();
    repeat (30) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
